// ----- sv/jrp_pkg.sv -----
// ----------------------------------------------------------------------------
// jrp_pkg
// Shared types, codes and lookup functions of the request parser.
// ----------------------------------------------------------------------------
package jrp_pkg;

  localparam int unsigned CapWidth  = 11;
  localparam int unsigned ByteWidth = 8;

  // configuration register indexes
  localparam logic CFG_CMD_CAP = 1'b0;
  localparam logic CFG_ARG_CAP = 1'b1;

  typedef enum logic [3:0] {
    PH_OPEN  = 4'd0,
    PH_KEY   = 4'd1,
    PH_STR   = 4'd2,
    PH_ESC   = 4'd3,
    PH_HEX   = 4'd4,
    PH_COLON = 4'd5,
    PH_VALUE = 4'd6,
    PH_AFTER = 4'd7,
    PH_DONE  = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    TGT_KEY = 2'd0,
    TGT_CMD = 2'd1,
    TGT_ARG = 2'd2
  } target_e;

  typedef enum logic [1:0] {
    KIND_CMD     = 2'd0,
    KIND_ARG     = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_e;

  typedef struct packed {
    phase_e                 phase;
    target_e                target;
    logic [2:0]             hex_left;
    logic [15:0]            hex_acc;
    logic [1:0]             keys_seen;
    logic [1:0]             cand;
    logic [3:0]             klen;
    logic [CapWidth-1:0]    vlen;
    logic                   cmd_nonempty;
    logic                   failed;
  } jrp_state_t;

  typedef struct packed {
    logic                 valid;
    kind_e                kind;
    logic [ByteWidth-1:0] character;
    logic                 accepted;
  } jrp_result_t;

  localparam jrp_state_t StateReset = '{
    phase:        PH_OPEN,
    target:       TGT_KEY,
    hex_left:     3'd0,
    hex_acc:      16'd0,
    keys_seen:    2'b00,
    cand:         2'b11,
    klen:         4'd0,
    vlen:         '0,
    cmd_nonempty: 1'b0,
    failed:       1'b0
  };

  // letters of the key "command"
  function automatic logic [7:0] cmd_letter(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = "c";
      4'd1:    r = "o";
      4'd2:    r = "m";
      4'd3:    r = "m";
      4'd4:    r = "a";
      4'd5:    r = "n";
      4'd6:    r = "d";
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // letters of the key "argument"
  function automatic logic [7:0] arg_letter(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = "a";
      4'd1:    r = "r";
      4'd2:    r = "g";
      4'd3:    r = "u";
      4'd4:    r = "m";
      4'd5:    r = "e";
      4'd6:    r = "n";
      4'd7:    r = "t";
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b inside {8'd32, [8'd9:8'd13]};
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {["0":"9"]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {["a":"f"]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b inside {["A":"F"]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ----- sv/jrp_in_stage.sv -----
// ----------------------------------------------------------------------------
// jrp_in_stage
// Input register: holds one text beat until the parser takes it.
// ----------------------------------------------------------------------------
module jrp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tlast,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load;

  assign s_axis_tready = !valid_q || take_i;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

// ----- sv/jrp_parser.sv -----
// ----------------------------------------------------------------------------
// jrp_parser
// Parse state and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module jrp_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  input  logic                   last_i,
  input  logic [jrp_pkg::CapWidth:0] cmd_cap_i,
  input  logic [jrp_pkg::CapWidth:0] arg_cap_i,
  output jrp_pkg::jrp_result_t   result_o
);
  import jrp_pkg::*;

  jrp_state_t state_q, state_d;

  always_comb begin
    jrp_state_t  s;
    jrp_result_t r;
    logic        take;
    logic [7:0]  ch;
    logic [4:0]  hv;
    logic [15:0] acc;
    logic [2:0]  left;
    logic [CapWidth:0] cap;
    logic        ok;

    s    = state_q;
    r    = '{valid: 1'b0, kind: KIND_CMD, character: 8'd0, accepted: 1'b0};
    take = 1'b0;
    ch   = byte_i;
    hv   = hex_digit(byte_i);
    acc  = {state_q.hex_acc[11:0], hv[3:0]};
    left = (state_q.hex_left != 3'd0) ? state_q.hex_left - 3'd1 : 3'd0;
    cap  = (state_q.target == TGT_CMD) ? cmd_cap_i : arg_cap_i;
    ok   = 1'b0;

    if (cmd_cap_i == '0 || arg_cap_i == '0 || byte_i == 8'd0) begin
      s.failed = 1'b1;
    end

    if (!s.failed) begin
      case (state_q.phase)
        PH_OPEN: begin
          if (!is_space(byte_i)) begin
            if (byte_i == "{") s.phase = PH_KEY;
            else s.failed = 1'b1;
          end
        end
        PH_KEY: begin
          if (!is_space(byte_i)) begin
            if (byte_i == "\"") begin
              s.phase  = PH_STR;
              s.target = TGT_KEY;
              s.cand   = 2'b11;
              s.klen   = 4'd0;
            end else begin
              s.failed = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          if (!is_space(byte_i)) begin
            if (byte_i == "\"") begin
              s.phase = PH_STR;
              s.vlen  = '0;
            end else begin
              s.failed = 1'b1;
            end
          end
        end
        PH_STR: begin
          if (byte_i == "\"") begin
            // closing quote of a key or a value
            if (state_q.target == TGT_KEY) begin
              if (state_q.klen == 4'd7 && state_q.cand[0] && !state_q.keys_seen[0]) begin
                s.keys_seen[0] = 1'b1;
                s.target       = TGT_CMD;
                s.phase        = PH_COLON;
              end else if (state_q.klen == 4'd8 && state_q.cand[1]
                           && !state_q.keys_seen[1]) begin
                s.keys_seen[1] = 1'b1;
                s.target       = TGT_ARG;
                s.phase        = PH_COLON;
              end else begin
                s.failed = 1'b1;
              end
            end else begin
              s.target = TGT_KEY;
              s.phase  = PH_AFTER;
            end
          end else if (byte_i < 8'd32) begin
            s.failed = 1'b1;
          end else if (byte_i == "\\") begin
            s.phase = PH_ESC;
          end else begin
            take = 1'b1;
          end
        end
        PH_ESC: begin
          case (byte_i)
            "\"", "\\", "/": take = 1'b1;
            "n": begin take = 1'b1; ch = 8'd10; end
            "r": begin take = 1'b1; ch = 8'd13; end
            "t": begin take = 1'b1; ch = 8'd9;  end
            "b": begin take = 1'b1; ch = 8'd8;  end
            "f": begin take = 1'b1; ch = 8'd12; end
            "u": begin
              s.phase    = PH_HEX;
              s.hex_left = 3'd4;
              s.hex_acc  = 16'd0;
            end
            default: s.failed = 1'b1;
          endcase
        end
        PH_HEX: begin
          if (!hv[4]) begin
            s.failed = 1'b1;
          end else begin
            s.hex_acc  = acc;
            s.hex_left = left;
            if (left == 3'd0) begin
              // code point must lie in 1..127
              if (acc == 16'd0 || acc[15:7] != 9'd0) begin
                s.failed = 1'b1;
              end else begin
                take = 1'b1;
                ch   = acc[7:0];
              end
            end
          end
        end
        PH_COLON: begin
          if (!is_space(byte_i)) begin
            if (byte_i == ":") s.phase = PH_VALUE;
            else s.failed = 1'b1;
          end
        end
        PH_AFTER: begin
          if (!is_space(byte_i)) begin
            if (byte_i == "}") s.phase = PH_DONE;
            else if (byte_i == ",") s.phase = PH_KEY;
            else s.failed = 1'b1;
          end
        end
        default: begin
          if (!is_space(byte_i)) s.failed = 1'b1;
        end
      endcase

      if (take) begin
        if (state_q.target == TGT_KEY) begin
          if (!(state_q.klen < 4'd7 && cmd_letter(state_q.klen) == ch)) s.cand[0] = 1'b0;
          if (!(state_q.klen < 4'd8 && arg_letter(state_q.klen) == ch)) s.cand[1] = 1'b0;
          if (state_q.klen != 4'd15) s.klen = state_q.klen + 4'd1;
          s.phase = PH_STR;
        end else if (({1'b0, state_q.vlen} + 1'b1) >= cap) begin
          s.failed = 1'b1;
        end else begin
          s.vlen  = state_q.vlen + 1'b1;
          s.phase = PH_STR;
          if (state_q.target == TGT_CMD) s.cmd_nonempty = 1'b1;
          if (!last_i) begin
            r.valid     = 1'b1;
            r.kind      = (state_q.target == TGT_CMD) ? KIND_CMD : KIND_ARG;
            r.character = ch;
          end
        end
      end
    end

    if (last_i) begin
      ok = !s.failed && s.phase == PH_DONE && s.keys_seen[0] && s.cmd_nonempty;
      r  = '{valid: 1'b1, kind: KIND_VERDICT, character: 8'd0, accepted: ok};
      s  = StateReset;
    end

    state_d        = s;
    result_o       = r;
    result_o.valid = r.valid && step_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/jrp_out_stage.sv -----
// ----------------------------------------------------------------------------
// jrp_out_stage
// Output register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module jrp_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jrp_pkg::jrp_result_t result_i,
  output logic                 space_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,
  output logic [1:0]           m_axis_tuser
);
  import jrp_pkg::*;

  logic       valid_q, valid_d;
  kind_e      kind_q;
  logic [7:0] char_q;
  logic       acc_q;

  assign space_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (result_i.valid) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.valid) begin
      kind_q <= result_i.kind;
      char_q <= result_i.character;
      acc_q  <= result_i.accepted;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {7'd0, acc_q, char_q};
  assign m_axis_tuser  = kind_q;

endmodule

// ----- sv/json_request_parser.sv -----
// ----------------------------------------------------------------------------
// json_request_parser
// Streaming parser for a flat JSON request object with "command" and
// "argument" string keys; emits decoded value characters and a verdict.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata                         | tuser       | tlast
//  ---------+-----------+-------------------------------+-------------+------------
//  s_axis   | in        | [7:0] text_byte               | -           | end_of_text
//  m_axis   | out       | [7:0] character, [8] accepted | result_kind | -
//  cfg      | in        | write port, index 0 command, 1 argument capacity
//
//  one text beat is taken every cycle while the output register has space; a beat's
//  result is loaded into the output register when the parser steps on that beat
//  the parse state update for one byte is combinational compare logic
//  reset is asynchronous, active low; no clearing pass is needed
//  a stalled result beat holds the parser, and a held parser stalls s_axis
//  a beat that gives no result still needs the output register to be free
//
module json_request_parser #(
  parameter int unsigned MAX_CAPACITY = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // text in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] text_byte
  input  logic                         s_axis_tlast,
  // results out
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // [7:0] character, [8] accepted
  output logic [1:0]                   m_axis_tuser,   // [1:0] result_kind
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [jrp_pkg::CapWidth-1:0] cfg_data_i
);
  import jrp_pkg::*;

  localparam int unsigned CapMax = (1 << CapWidth) - 1;
  // capacity clamp; above the register range it never takes effect
  localparam logic [CapWidth:0] CapLimit =
    (MAX_CAPACITY > CapMax) ? (CapWidth+1)'(CapMax) : (CapWidth+1)'(MAX_CAPACITY);

  logic [CapWidth-1:0] cmd_cap_q, arg_cap_q;
  logic [CapWidth:0]   cmd_eff, arg_eff;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_space;
  logic        step;
  jrp_result_t result;

  // capacity registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_cap_q <= CapWidth'(256);
      arg_cap_q <= CapWidth'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CMD_CAP: cmd_cap_q <= cfg_data_i;
        CFG_ARG_CAP: arg_cap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cmd_eff = ({1'b0, cmd_cap_q} > CapLimit) ? CapLimit : {1'b0, cmd_cap_q};
  assign arg_eff = ({1'b0, arg_cap_q} > CapLimit) ? CapLimit : {1'b0, arg_cap_q};

  // parser advances when a byte is held and the output register can take a beat
  assign step = in_valid && out_space;

  jrp_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .take_i        (step),
    .valid_o       (in_valid),
    .byte_o        (in_byte),
    .last_o        (in_last)
  );

  jrp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte),
    .last_i    (in_last),
    .cmd_cap_i (cmd_eff),
    .arg_cap_i (arg_eff),
    .result_o  (result)
  );

  jrp_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .result_i      (result),
    .space_o       (out_space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming JSON request parser. Text bytes are
// fed on s_axis under random idling, every accepted byte is run through a
// local parser model, and each result beat on m_axis is compared against
// the oldest predicted beat. A short table of hand-written requests comes
// first, then random requests under several capacity settings.
// ----------------------------------------------------------------------------
module tb_top;
  import jrp_pkg::*;

  localparam int HalfPeriod          = 2;
  localparam int ResetCycles         = 12;
  localparam int CycleLimit          = 200000;
  localparam int DrainCycles         = 8;     // output pipe is two deep, keep some slack
  localparam int HoldCycles          = 300;   // long receiver stall, fills the pipe
  localparam int MaxCap              = 1024;
  localparam int RandomBytesPerPhase = 96;
  localparam int ShownMismatches     = 10;
  localparam int ValueLenMax         = 9;

  // structural characters of the request text
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // capacity settings of the random phases, extremes and zero among them
  localparam int CmdCaps[9] = '{256, 5, 1024, 2, 2047, 8, 3, 300, 256};
  localparam int ArgCaps[9] = '{256, 3, 2047, 6, 1023, 0, 4, 7, 256};

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic       acc;
  } parse_out_t;

  // one hand-written request; nul_at puts a zero byte there, -1 keeps
  // capacities or leaves the verdict to the model
  typedef struct {
    string text;
    int    nul_at;
    int    cmd_cap;
    int    arg_cap;
    int    verdict;
  } text_case_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [CapWidth-1:0] cfg_data_i;

  always #HalfPeriod clk_i = ~clk_i;

  json_request_parser #(
    .MAX_CAPACITY(MaxCap)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // parser model: own copy of registers and parse state
  // --------------------------------------------------------------------------
  logic [CapWidth-1:0] cmd_cap_reg;
  logic [CapWidth-1:0] arg_cap_reg;

  phase_e      cur_phase;
  target_e     cur_target;
  int          hex_count;
  logic [15:0] hex_value_acc;
  logic [1:0]  keys_found;     // bit0 command, bit1 argument
  logic [1:0]  key_match;      // key could still be command / argument
  int          key_len;        // saturates at 15
  int          val_len;
  bit          cmd_has_char;
  bit          req_failed;

  string cmd_word = "command";
  string arg_word = "argument";

  parse_out_t parser_out_q[$];

  int  fault_count   = 0;
  int  send_idle_pct = 28;
  int  recv_idle_pct = 46;
  int  beats_sent    = 0;
  int  cycle_count   = 0;
  bit  hold_req      = 1'b0;
  int  hold_left     = 0;

  logic [7:0] req_bytes[$];
  text_case_t cases[$];

  string esc_chars = "\"\\/nrtbf";
  string odd_keys[6] = '{"comman", "commandd", "argumen", "Command", "x", ""};

  function automatic bit is_blank(logic [7:0] b);
    return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic void push_expected(kind_e k, logic [7:0] ch, logic acc);
    parser_out_q.push_back('{kind: k, ch: ch, acc: acc});
  endfunction

  function automatic void clear_parse();
    cur_phase     = PH_OPEN;
    cur_target    = TGT_KEY;
    hex_count     = 0;
    hex_value_acc = '0;
    keys_found    = 2'b00;
    key_match     = 2'b11;
    key_len       = 0;
    val_len       = 0;
    cmd_has_char  = 1'b0;
    req_failed    = 1'b0;
  endfunction

  // one decoded string character, either part of a key or of a value
  function automatic void decode_char(logic [7:0] ch, bit last);
    int cap;
    if (cur_target == TGT_KEY) begin
      if (!(key_len < 7 && cmd_word[key_len] == ch)) key_match[0] = 1'b0;
      if (!(key_len < 8 && arg_word[key_len] == ch)) key_match[1] = 1'b0;
      if (key_len < 15) key_len++;
      cur_phase = PH_STR;
      return;
    end
    cap = (cur_target == TGT_CMD) ? cmd_cap_reg : arg_cap_reg;
    if (cap > MaxCap) cap = MaxCap;
    // the character that would make the length reach the capacity fails
    if (val_len + 1 >= cap) begin
      req_failed = 1'b1;
      return;
    end
    val_len++;
    cur_phase = PH_STR;
    if (cur_target == TGT_CMD) cmd_has_char = 1'b1;
    // a character decoded from the final byte is never emitted
    if (!last) push_expected((cur_target == TGT_CMD) ? KIND_CMD : KIND_ARG, ch, 1'b0);
  endfunction

  function automatic void decode_text_byte(logic [7:0] b, bit last);
    int nib;
    if (cmd_cap_reg == 0 || arg_cap_reg == 0) req_failed = 1'b1;
    if (b == 8'd0) req_failed = 1'b1;
    if (!req_failed) begin
      case (cur_phase)
        PH_OPEN: begin
          if (!is_blank(b)) begin
            if (b == CH_LBRACE) cur_phase = PH_KEY;
            else req_failed = 1'b1;
          end
        end
        PH_KEY: begin
          if (!is_blank(b)) begin
            if (b == CH_QUOTE) begin
              cur_phase  = PH_STR;
              cur_target = TGT_KEY;
              key_match  = 2'b11;
              key_len    = 0;
            end else begin
              req_failed = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          if (!is_blank(b)) begin
            if (b == CH_QUOTE) begin
              cur_phase = PH_STR;
              val_len   = 0;
            end else begin
              req_failed = 1'b1;
            end
          end
        end
        PH_STR: begin
          if (b == CH_QUOTE) begin
            if (cur_target == TGT_KEY) begin
              // key closes: must be a known key not seen before
              if (key_len == 7 && key_match[0] && !keys_found[0]) begin
                keys_found[0] = 1'b1;
                cur_target    = TGT_CMD;
                cur_phase     = PH_COLON;
              end else if (key_len == 8 && key_match[1] && !keys_found[1]) begin
                keys_found[1] = 1'b1;
                cur_target    = TGT_ARG;
                cur_phase     = PH_COLON;
              end else begin
                req_failed = 1'b1;
              end
            end else begin
              cur_target = TGT_KEY;
              cur_phase  = PH_AFTER;
            end
          end else if (b < 8'd32) begin
            req_failed = 1'b1;
          end else if (b == CH_BSLASH) begin
            cur_phase = PH_ESC;
          end else begin
            decode_char(b, last);
          end
        end
        PH_ESC: begin
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: decode_char(b, last);
            "n": decode_char(8'd10, last);
            "r": decode_char(8'd13, last);
            "t": decode_char(8'd9, last);
            "b": decode_char(8'd8, last);
            "f": decode_char(8'd12, last);
            "u": begin
              cur_phase     = PH_HEX;
              hex_count     = 4;
              hex_value_acc = '0;
            end
            default: req_failed = 1'b1;
          endcase
        end
        PH_HEX: begin
          nib = -1;
          if (b >= "0" && b <= "9") nib = b - "0";
          else if (b >= "a" && b <= "f") nib = b - "a" + 10;
          else if (b >= "A" && b <= "F") nib = b - "A" + 10;
          if (nib < 0) begin
            req_failed = 1'b1;
          end else begin
            hex_value_acc = {hex_value_acc[11:0], 4'(nib)};
            if (hex_count > 0) hex_count--;
            if (hex_count == 0) begin
              if (hex_value_acc == 16'd0 || hex_value_acc > 16'd127) req_failed = 1'b1;
              else decode_char(hex_value_acc[7:0], last);
            end
          end
        end
        PH_COLON: begin
          if (!is_blank(b)) begin
            if (b == CH_COLON) cur_phase = PH_VALUE;
            else req_failed = 1'b1;
          end
        end
        PH_AFTER: begin
          if (!is_blank(b)) begin
            if (b == CH_RBRACE) cur_phase = PH_DONE;
            else if (b == CH_COMMA) cur_phase = PH_KEY;
            else req_failed = 1'b1;
          end
        end
        default: begin
          // only blanks may follow the closing brace
          if (!is_blank(b)) req_failed = 1'b1;
        end
      endcase
    end
    if (last) begin
      push_expected(KIND_VERDICT, 8'd0,
                    !req_failed && cur_phase == PH_DONE && keys_found[0] && cmd_has_char);
      clear_parse();
    end
  endfunction

  // --------------------------------------------------------------------------
  // request text builders, all append to req_bytes
  // --------------------------------------------------------------------------
  function automatic void put_word(string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endfunction

  function automatic void put_blank();
    int r;
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        r = $urandom_range(0, 5);
        req_bytes.push_back((r == 5) ? CH_SPACE : 8'(9 + r));
      end
    end
  endfunction

  // four hex digits, letters in random case
  function automatic void put_hex4(int v);
    int n;
    for (int i = 3; i >= 0; i--) begin
      n = (v >> (4 * i)) & 15;
      if (n < 10) req_bytes.push_back(8'("0" + n));
      else req_bytes.push_back(8'(($urandom_range(0, 1) ? "a" : "A") + n - 10));
    end
  endfunction

  // one decoded character worth of string text, now and then a broken one
  function automatic void put_piece();
    int r;
    int c;
    r = $urandom_range(0, 99);
    if (r < 58) begin
      c = $urandom_range(32, 126);
      if (c == CH_QUOTE || c == CH_BSLASH) req_bytes.push_back(CH_BSLASH);
      req_bytes.push_back(8'(c));
    end else if (r < 68) begin
      req_bytes.push_back(8'($urandom_range(128, 255)));
    end else if (r < 84) begin
      req_bytes.push_back(CH_BSLASH);
      req_bytes.push_back(esc_chars[$urandom_range(0, 7)]);
    end else if (r < 96) begin
      put_word("\\u");
      put_hex4($urandom_range(1, 127));
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          put_word("\\u");
          put_hex4($urandom_range(0, 1) ? 0 : $urandom_range(128, 65535));
        end
        1: begin
          req_bytes.push_back(CH_BSLASH);
          put_word(odd_keys[$urandom_range(0, 4)].substr(0, 0));
        end
        default: req_bytes.push_back(8'($urandom_range(1, 31)));
      endcase
    end
  endfunction

  function automatic void put_string(string s);
    req_bytes.push_back(CH_QUOTE);
    put_word(s);
    req_bytes.push_back(CH_QUOTE);
  endfunction

  // mostly well-formed requests with random content, some broken, some noise
  function automatic void build_request();
    int layout;
    int nkeys;
    int r;
    int n;
    int keys[3];
    req_bytes.delete();
    layout = $urandom_range(0, 19);
    nkeys  = 2;
    if (layout < 7) begin
      nkeys = 1; keys[0] = 0;
    end else if (layout < 13) begin
      keys[0] = 0; keys[1] = 1;
    end else if (layout < 18) begin
      keys[0] = 1; keys[1] = 0;
    end else if (layout == 18) begin
      nkeys = 1; keys[0] = 1;
    end else begin
      // empty object or a duplicated key
      r = $urandom_range(0, 2);
      if (r == 0) nkeys = 0;
      keys[0] = r - 1; keys[1] = r - 1;
    end
    put_blank();
    req_bytes.push_back(CH_LBRACE);
    put_blank();
    for (int i = 0; i < nkeys; i++) begin
      if (i > 0) begin
        put_blank();
        req_bytes.push_back(CH_COMMA);
        put_blank();
      end
      if ($urandom_range(0, 99) < 6) put_string(odd_keys[$urandom_range(0, 5)]);
      else put_string(keys[i] == 0 ? cmd_word : arg_word);
      put_blank();
      req_bytes.push_back(CH_COLON);
      put_blank();
      req_bytes.push_back(CH_QUOTE);
      repeat ($urandom_range(0, ValueLenMax)) put_piece();
      req_bytes.push_back(CH_QUOTE);
    end
    put_blank();
    req_bytes.push_back(CH_RBRACE);
    put_blank();

    r = $urandom_range(0, 99);
    if (r < 72) begin
      // keep as built
    end else if (r < 82) begin
      req_bytes[$urandom_range(0, req_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (r < 90) begin
      n = $urandom_range(1, req_bytes.size());
      while (req_bytes.size() > n) void'(req_bytes.pop_back());
    end else begin
      req_bytes.delete();
      repeat ($urandom_range(1, 10)) req_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic add_case(string text, int nul_at, int cmd_cap, int arg_cap, int verdict);
    text_case_t tc;
    tc.text    = text;
    tc.nul_at  = nul_at;
    tc.cmd_cap = cmd_cap;
    tc.arg_cap = arg_cap;
    tc.verdict = verdict;
    cases.push_back(tc);
  endtask

  // offer one text beat; valid is only lowered when an idle cycle is taken,
  // so back-to-back beats never see two assignments in one step
  task automatic send_beat(logic [7:0] b, bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_sent++;
    decode_text_byte(b, last);
  endtask

  task automatic send_request();
    foreach (req_bytes[i]) send_beat(req_bytes[i], i == req_bytes.size() - 1);
  endtask

  // wait for every predicted beat, then for the pipe to go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (parser_out_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cap(logic idx, int val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CapWidth'(val);
    @(posedge clk_i);
    if (idx == CFG_CMD_CAP) cmd_cap_reg = CapWidth'(val);
    else arg_cap_reg = CapWidth'(val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // result side: random ready, long hold on request, compare each beat
  // --------------------------------------------------------------------------
  initial begin : result_side
    parse_out_t  want;
    logic [15:0] want_data;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (parser_out_q.size() == 0) begin
          fault_count++;
          if (fault_count <= ShownMismatches) begin
            $display("unexpected result beat: kind %0d data %04h", m_axis_tuser, m_axis_tdata);
          end
        end else begin
          want      = parser_out_q.pop_front();
          want_data = {7'd0, want.acc, want.ch};
          if (m_axis_tuser !== want.kind || m_axis_tdata !== want_data) begin
            fault_count++;
            if (fault_count <= ShownMismatches) begin
              $display("result mismatch: exp kind %0d data %04h, got kind %0d data %04h",
                       want.kind, want_data, m_axis_tuser, m_axis_tdata);
            end
          end
        end
      end
      // a hold request turns into a counted stretch with ready low
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int idx;
    int start;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_CMD_CAP;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    cmd_cap_reg   = CapWidth'(256);
    arg_cap_reg   = CapWidth'(256);
    clear_parse();

    // directed requests: text, zero byte position, caps, typed verdict
    add_case("{\"command\":\"ls\"}", -1, -1, -1, 1);
    // blanks everywhere, both keys, every simple escape
    add_case(" \t{ \"argument\" : \"a\\\"b\\\\c\\/d\" , \"command\":\"x\\n\\r\\t\\b\\f\"}\n",
             -1, -1, -1, -1);
    // unicode escapes at the top of the range, both digit cases
    add_case("{\"command\":\"\\u0041\\u007f\\u007F\"}", -1, -1, -1, -1);
    add_case("{\"command\":\"\\u0000\"}", -1, -1, -1, 0);
    add_case("{\"command\":\"\\u0080\"}", -1, -1, -1, 0);
    add_case("{\"command\":\"\\q\"}", -1, -1, -1, 0);
    // raw control byte inside a value
    add_case("{\"command\":\"a\tb\"}", -1, -1, -1, 0);
    add_case("{}", -1, -1, -1, 0);
    add_case("{\"argument\":\"z\"}", -1, -1, -1, 0);
    add_case("{\"command\":\"\"}", -1, -1, -1, 0);
    add_case("{\"command\":\"a\",\"command\":\"b\"}", -1, -1, -1, 0);
    add_case("{\"commands\":\"a\"}", -1, -1, -1, 0);
    // unterminated: last character is decoded but not emitted
    add_case("{\"command\":\"abc", -1, -1, -1, 0);
    // zero byte in the middle of the value
    add_case("{\"command\":\"aXb\"}", 13, -1, -1, 0);
    // top byte values are plain characters
    add_case("{\"command\":\"\377\200\"}", -1, -1, -1, 1);
    // failure is sticky, nothing after it is emitted
    add_case("x{\"command\":\"a\"}", -1, -1, -1, 0);
    add_case("{\"command\":\"a\"}x", -1, -1, -1, 0);
    // zero capacity on either register rejects everything
    add_case("{\"command\":\"a\"}", -1, 0, -1, 0);
    add_case("{\"command\":\"a\"}", -1, 256, 0, 0);
    // capacity one leaves no room, top value counts as the maximum
    add_case("{\"command\":\"a\"}", -1, 1, 2047, 0);
    add_case("{\"command\":\"ab\",\"argument\":\"cd\"}", -1, 3, -1, 1);
    add_case("{\"command\":\"abc\"}", -1, -1, -1, 0);
    add_case("}", -1, 256, 256, 0);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (cases[i]) begin
      if (cases[i].cmd_cap >= 0 || cases[i].arg_cap >= 0) begin
        settle();
        if (cases[i].cmd_cap >= 0) write_cap(CFG_CMD_CAP, cases[i].cmd_cap);
        if (cases[i].arg_cap >= 0) write_cap(CFG_ARG_CAP, cases[i].arg_cap);
      end
      req_bytes.delete();
      for (int k = 0; k < cases[i].text.len(); k++) begin
        req_bytes.push_back((k == cases[i].nul_at) ? 8'd0 : cases[i].text[k]);
      end
      send_request();
      // typed verdict replaces the model's for this row
      if (cases[i].verdict >= 0) begin
        parser_out_q[parser_out_q.size() - 1].acc = cases[i].verdict[0];
      end
    end

    // random part: three idling modes, three capacity settings each
    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 28 : (m == 1) ? 46 : 0;
      recv_idle_pct = (m == 0) ? 46 : (m == 1) ? 28 : 0;
      for (int j = 0; j < 3; j++) begin
        idx = m * 3 + j;
        settle();
        write_cap(CFG_CMD_CAP, CmdCaps[idx]);
        write_cap(CFG_ARG_CAP, ArgCaps[idx]);
        // receiver stalls a long stretch while text keeps coming
        if (m == 2 && j == 0) hold_req = 1'b1;
        start = beats_sent;
        while (beats_sent - start < RandomBytesPerPhase) begin
          build_request();
          send_request();
        end
      end
    end

    settle();
    if (fault_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
